// ===== rtl/core/spq_pkg.sv =====
// shared types and constants for the stable priority queue
`default_nettype none
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int PRI_W   = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic [PRI_W-1:0]   priority_req;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] popped_value;
    logic [PRI_W-1:0]   popped_priority;
    logic [1:0]         status;
    logic [CNT_W-1:0]   occupancy;
  } out_rsp_t;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop;
    logic [1:0] status;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/stable_priority_queue.sv =====
// top level of the stable priority queue
//
//   port group   direction  payload             handshake
//   in_*         input      spq_pkg::in_req_t   in_valid / in_ready
//   out_*        output     spq_pkg::out_rsp_t  out_valid / out_ready
//
// each request is applied in the cycle it is accepted; its response is
// registered and shows on out_* the following cycle
// a new request is taken while the response register is empty or being drained,
// so with out_ready high one request per cycle flows through
// a stalled response holds in_ready low until it is taken
// rst_n clears the occupancy count and the response valid; cell contents are
// not cleared since only cells below the count are ever read
`default_nettype none
module stable_priority_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spq_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output spq_pkg::out_rsp_t      out_rsp
);

  spq_pkg::ctl_cmd_t cmd;
  spq_pkg::dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_req.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .cmd   (cmd),
    .stat  (stat),
    .rsp   (out_rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// handshake and command controller for the stable priority queue
`default_nettype none
module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spq_pkg::dp_stat_t stat,
  output spq_pkg::ctl_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.load   = accept;
    cmd.push   = 1'b0;
    cmd.pop    = 1'b0;
    cmd.status = spq_pkg::ST_OK;
    unique case (in_action)
      spq_pkg::ACT_PUSH: begin
        if (stat.full) begin
          cmd.status = spq_pkg::ST_FULL;
        end else begin
          cmd.push = accept;
        end
      end
      spq_pkg::ACT_POP: begin
        if (stat.empty) begin
          cmd.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.pop = accept;
        end
      end
      default: cmd.status = spq_pkg::ST_OK;
    endcase
  end

  always_comb begin
    priority if (accept) begin
      state_nxt = S_HOLD;
    end else if (out_ready) begin
      state_nxt = S_IDLE;
    end else begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/spq_dp.sv =====
// sorted cell array, occupancy count and response register
`default_nettype none
module spq_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire spq_pkg::in_req_t          req,
  input  wire spq_pkg::ctl_cmd_t         cmd,
  output spq_pkg::dp_stat_t              stat,
  output spq_pkg::out_rsp_t              rsp
);

  localparam int DEPTH   = spq_pkg::DEPTH;
  localparam int VALUE_W = spq_pkg::VALUE_W;
  localparam int PRI_W   = spq_pkg::PRI_W;
  localparam int CNT_W   = spq_pkg::CNT_W;

  logic [VALUE_W-1:0] val_r   [DEPTH];
  logic [VALUE_W-1:0] val_nxt [DEPTH];
  logic [PRI_W-1:0]   pri_r   [DEPTH];
  logic [PRI_W-1:0]   pri_nxt [DEPTH];
  logic [DEPTH-1:0]   ge;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  spq_pkg::out_rsp_t  rsp_r;
  spq_pkg::out_rsp_t  rsp_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));

  // cells at or above new priority stay in place
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic prev_ge;

    assign ge[g] = (CNT_W'(g) < count_r) && (pri_r[g] >= req.priority_req);

    if (g == 0) begin : g_first
      assign prev_ge = 1'b1;
    end else begin : g_rest
      assign prev_ge = ge[g-1];
    end

    always_comb begin
      val_nxt[g] = val_r[g];
      pri_nxt[g] = pri_r[g];
      if (cmd.push && !ge[g]) begin
        if (prev_ge) begin
          val_nxt[g] = req.value;
          pri_nxt[g] = req.priority_req;
        end else begin
          val_nxt[g] = val_r[(g == 0) ? 0 : g - 1];
          pri_nxt[g] = pri_r[(g == 0) ? 0 : g - 1];
        end
      end else if (cmd.pop && (g < DEPTH - 1)) begin
        val_nxt[g] = val_r[(g < DEPTH - 1) ? g + 1 : g];
        pri_nxt[g] = pri_r[(g < DEPTH - 1) ? g + 1 : g];
      end
    end

    always_ff @(posedge clk) begin
      val_r[g] <= val_nxt[g];
      pri_r[g] <= pri_nxt[g];
    end
  end

  always_comb begin
    priority if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    rsp_nxt = rsp_r;
    if (cmd.load) begin
      rsp_nxt.popped_value    = cmd.pop ? val_r[0] : '0;
      rsp_nxt.popped_priority = cmd.pop ? pri_r[0] : '0;
      rsp_nxt.status          = cmd.status;
      rsp_nxt.occupancy       = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign rsp = rsp_r;

endmodule
`default_nettype wire
